>>> hdl/assert_macros.svh
// Assertion macros for the checker file rqsff_chk.sv.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rqsff_pkg.sv
// Types and codes for the job queue scheduler.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package rqsff_pkg;

  localparam int SIZE_W  = 32;
  localparam int TAG_W   = 16;
  localparam int COUNT_W = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] MODE_FIFO  = 2'd0;
  localparam logic [1:0] MODE_SFF   = 2'd1;
  localparam logic [1:0] MODE_GROUP = 2'd2;

  localparam logic [1:0] REG_ORDER_MODE   = 2'd0;
  localparam logic [1:0] REG_GROUP_LENGTH = 2'd1;
  localparam logic [1:0] REG_CAPACITY     = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_CMP  = 4'b0100,
    S_DEQ  = 4'b1000
  } state_t;

endpackage

>>> hdl/request_queue_sff_scheduler.sv
// Job queue scheduler with FIFO, shortest-first and grouped shortest-first order.
// Depends on rqsff_pkg; entries live in one circular memory with registered read.
//
//   channel  | handshake        | beat
//   ---------+------------------+----------------------------------------
//   command  | start / busy     | opcode, job_size, job_tag
//   result   | done (strobe)    | status, head_tag, head_size, fill_level
//   config   | cfg_write        | cfg_index, cfg_data
//
// Enqueue: a read-compare-write loop on the single-port entry memory walks from
// the tail, moves each larger entry up one place and writes the new entry where
// the scan stops. Dequeue reads the head entry. Refused or empty: done next cycle.
// Reset (rst, synchronous) empties the queue and restores the register defaults.
// done is high for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module request_queue_sff_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [rqsff_pkg::SIZE_W-1:0]  job_size,
  input  logic [rqsff_pkg::TAG_W-1:0]   job_tag,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [rqsff_pkg::TAG_W-1:0]   head_tag,
  output logic [rqsff_pkg::SIZE_W-1:0]  head_size,
  output logic [rqsff_pkg::COUNT_W-1:0] fill_level,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_data
);
  import rqsff_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
  localparam logic [COUNT_W-1:0] CAP_MAX =
    COUNT_W'((QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH);

  state_t               state;
  logic [1:0]           order_mode;
  logic [7:0]           group_length;
  logic [COUNT_W-1:0]   capacity;
  logic [COUNT_W-1:0]   count;
  logic [7:0]           ticket;
  logic [COUNT_W-1:0]   gsi;
  logic [AW-1:0]        head;
  logic [COUNT_W-1:0]   pos;
  logic [COUNT_W-1:0]   lo;
  entry_t               new_entry;
  entry_t               rdata;
  entry_t               mem [QUEUE_DEPTH];

  logic                 accept;
  logic [COUNT_W-1:0]   cap_eff;
  logic [7:0]           gl_eff;
  logic [7:0]           t_cur;
  logic [8:0]           t_inc;
  logic [7:0]           t_adv;
  logic [COUNT_W-1:0]   enq_lo;
  logic                 enq_full;
  logic                 rd_walk;
  logic                 shift_now;
  logic                 ins_now;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  entry_t               mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [COUNT_W-1:0] l);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(l);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (capacity == '0) cap_eff = COUNT_W'(1);
    else if (capacity > CAP_MAX) cap_eff = CAP_MAX;
    else cap_eff = capacity;
    gl_eff   = (group_length == 8'd0) ? 8'd1 : group_length;
    t_cur    = (ticket >= gl_eff) ? 8'd0 : ticket;
    t_inc    = {1'b0, t_cur} + 9'd1;
    t_adv    = (t_inc >= {1'b0, gl_eff}) ? 8'd0 : t_inc[7:0];
    enq_full = (count >= cap_eff);
    case (order_mode)
      MODE_SFF: enq_lo = '0;
      MODE_GROUP: begin
        if (count == '0 || t_cur == 8'd0) enq_lo = count;
        else enq_lo = (gsi < count) ? gsi : '0;
      end
      default: enq_lo = count;
    endcase
  end

  always_comb begin
    rd_walk   = (state == S_WALK) && (pos > lo);
    shift_now = (state == S_CMP) && (rdata.size > new_entry.size);
    ins_now   = ((state == S_WALK) && !(pos > lo)) ||
                ((state == S_CMP) && !(rdata.size > new_entry.size));
    mem_we    = shift_now || ins_now;
    mem_waddr = phys(head, pos);
    mem_wdata = shift_now ? rdata : new_entry;
    mem_re    = rd_walk || (accept && opcode == OP_DEQ);
    mem_raddr = rd_walk ? phys(head, pos - COUNT_W'(1)) : head;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      order_mode   <= MODE_FIFO;
      group_length <= 8'd4;
      capacity     <= COUNT_W'(16);
      count        <= '0;
      ticket       <= '0;
      gsi          <= '0;
      head         <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_ORDER_MODE:   order_mode   <= cfg_data[1:0];
          REG_GROUP_LENGTH: group_length <= cfg_data;
          REG_CAPACITY:     capacity     <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == OP_ENQ) begin
              if (enq_full) begin
                done <= 1'b1;
              end else begin
                state <= S_WALK;
                if (order_mode == MODE_GROUP) begin
                  ticket <= t_adv;
                  if (count == '0) gsi <= '0;
                  else if (t_cur == 8'd0) gsi <= count;
                end
              end
            end else begin
              if (count == '0) done <= 1'b1;
              else state <= S_DEQ;
            end
          end
        end
        S_WALK: begin
          if (rd_walk) begin
            state <= S_CMP;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
            count <= count + COUNT_W'(1);
          end
        end
        S_CMP: begin
          if (shift_now) begin
            state <= S_WALK;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
            count <= count + COUNT_W'(1);
          end
        end
        S_DEQ: begin
          state <= S_IDLE;
          done  <= 1'b1;
          count <= count - COUNT_W'(1);
          head  <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
          if (count == COUNT_W'(1)) gsi <= '0;
          else if (gsi != '0) gsi <= gsi - COUNT_W'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Beat registers and scan position.
  always_ff @(posedge clk) begin
    if (accept) begin
      new_entry.size <= job_size;
      new_entry.tag  <= job_tag;
      pos            <= count;
      lo             <= enq_lo;
      head_tag       <= '0;
      head_size      <= '0;
      fill_level     <= count;
      if (opcode == OP_ENQ) status <= enq_full ? ST_FULL : ST_DONE;
      else status <= (count == '0) ? ST_EMPTY : ST_DONE;
    end
    if (shift_now) pos <= pos - COUNT_W'(1);
    if (ins_now) fill_level <= count + COUNT_W'(1);
    if (state == S_DEQ) begin
      head_tag   <= rdata.tag;
      head_size  <= rdata.size;
      fill_level <= count - COUNT_W'(1);
    end
  end

endmodule

>>> hdl/rqsff_chk.sv
// Port-level checker for the job queue scheduler, bound to the top level.
// Depends on rqsff_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rqsff_chk #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    status,
  input logic [rqsff_pkg::TAG_W-1:0]   head_tag,
  input logic [rqsff_pkg::SIZE_W-1:0]  head_size,
  input logic [rqsff_pkg::COUNT_W-1:0] fill_level
);
  import rqsff_pkg::*;

  `CHK_ASSERT(a_accept_progress, start && !busy |=> busy || done, "accepted beat stalled")
  `CHK_ASSERT(a_busy_ends_done, $fell(busy) |-> done, "busy dropped without a result")
  `CHK_ASSERT(a_fail_zero, done && status != ST_DONE |-> head_tag == '0 && head_size == '0, "refused beat carries data")
  `CHK_ASSERT(a_empty_level, done && status == ST_EMPTY |-> fill_level == '0, "empty report with entries held")
  `CHK_ASSERT_ALWAYS(a_level_bound, done |-> int'(fill_level) <= QUEUE_DEPTH, "fill level beyond depth")

endmodule

bind request_queue_sff_scheduler rqsff_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rqsff_chk (.*);
